### src/lod_patch_index_generator_macros.svh
// assertion macros for the patch index generator
// included by the top level; no other dependencies
`ifndef LOD_PATCH_INDEX_GENERATOR_MACROS_SVH
`define LOD_PATCH_INDEX_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define LODPIG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lodpig: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LODPIG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lodpig: next-cycle check failed");

`endif

### src/lodpig_pkg.sv
// shared types, widths and codes of the patch index generator
// no dependencies; imported by every module of the block
package lodpig_pkg;

   localparam int MAX_CHUNK_LOG2_DEF = 8;

   localparam int VERTEX_W = 17;
   localparam int COUNT_W  = 18;
   localparam int LEVEL_W  = 3;
   localparam int CHUNK_W  = 4;
   localparam int SUB_W    = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * VERTEX_W - COUNT_W - 1;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 4'd5;

   // request kinds carried on tuser
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // triangle position inside a cell or a fan step
   localparam logic [SUB_W-1:0] SUB_FIRST = 2'd0;
   localparam logic [SUB_W-1:0] SUB_MID   = 2'd1;
   localparam logic [SUB_W-1:0] SUB_LAST  = 2'd2;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_INNER = 7'b0000010,
      PH_UP    = 7'b0000100,
      PH_DOWN  = 7'b0001000,
      PH_LEFT  = 7'b0010000,
      PH_RIGHT = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic down;
      logic up;
      logic right;
      logic left;
   } edges_type;

   typedef struct packed {
      phase_type        phase;
      logic [SUB_W-1:0] sub;
   } walk_type;

   // phases that still produce triangles
   function automatic logic phase_active(input phase_type p);
      phase_active = !(p == PH_IDLE || p == PH_DONE);
   endfunction

endpackage

### src/lodpig_seek.sv
// finds the next triangle of the list at or after a given walk position
// depends on lodpig_pkg
module lodpig_seek import lodpig_pkg::*; #(
   parameter int CW = MAX_CHUNK_LOG2_DEF + 1
) (
   input  walk_type        cur_walk,
   input  logic [CW-1:0]   cur_x,
   input  logic [CW-1:0]   cur_y,
   input  logic [CW-1:0]   cells,
   input  edges_type       edges,
   output walk_type        nxt_walk,
   output logic [CW-1:0]   nxt_x,
   output logic [CW-1:0]   nxt_y
);

   localparam int EW = CW + 1;

   logic [EW-1:0] ne, xe, ye, lw, rw, uw, dw, along;
   logic          x_fit, y_fit, row_ok_cur, row_ok_nxt, col_ok_cur;
   logic          is_row_fan, f0, f2, cells_nz;
   logic          after_up, after_down, after_left, after_right;
   logic          cand_ok;
   walk_type      cand_walk;
   logic [CW-1:0] cand_x, cand_y;

   // widened operands so sums never wrap
   assign ne = {1'b0, cells};
   assign xe = {1'b0, cur_x};
   assign ye = {1'b0, cur_y};
   assign lw = EW'(edges.left);
   assign rw = EW'(edges.right);
   assign uw = EW'(edges.up);
   assign dw = EW'(edges.down);
   assign cells_nz = (cells != '0);

   // interior rectangle bounds after trimming stitched borders
   assign x_fit      = (lw + rw + EW'(1)) <= ne;
   assign y_fit      = (uw + dw + EW'(1)) <= ne;
   assign row_ok_cur = (ye >= uw) && ((ye + dw + EW'(1)) <= ne);
   assign row_ok_nxt = (ye + dw + EW'(2)) <= ne;
   assign col_ok_cur = (xe >= lw) && ((xe + rw + EW'(1)) <= ne);

   // fan walking axis and corner drop flags
   assign is_row_fan = (cur_walk.phase == PH_UP) || (cur_walk.phase == PH_DOWN);
   assign along      = is_row_fan ? xe : ye;
   assign f0         = is_row_fan ? edges.left : edges.up;
   assign f2         = is_row_fan ? edges.right : edges.down;

   // phases that follow the current one
   assign after_up    = (cur_walk.phase == PH_INNER);
   assign after_down  = after_up || (cur_walk.phase == PH_UP);
   assign after_left  = after_down || (cur_walk.phase == PH_DOWN);
   assign after_right = after_left || (cur_walk.phase == PH_LEFT);

   // first present position inside the current phase
   always_comb begin
      cand_ok   = 1'b0;
      cand_walk = cur_walk;
      cand_x    = cur_x;
      cand_y    = cur_y;
      case (cur_walk.phase)
         PH_INNER: begin
            if (uw > ye) begin
               cand_ok       = x_fit && y_fit;
               cand_x        = CW'(edges.left);
               cand_y        = CW'(edges.up);
               cand_walk.sub = SUB_FIRST;
            end else if (row_ok_cur) begin
               if (lw > xe) begin
                  cand_ok       = x_fit;
                  cand_x        = CW'(edges.left);
                  cand_walk.sub = SUB_FIRST;
               end else if (col_ok_cur) begin
                  cand_ok = 1'b1;
               end else begin
                  cand_ok       = x_fit && row_ok_nxt;
                  cand_x        = CW'(edges.left);
                  cand_y        = cur_y + CW'(1);
                  cand_walk.sub = SUB_FIRST;
               end
            end
         end
         PH_UP, PH_DOWN, PH_LEFT, PH_RIGHT: begin
            if (along >= ne) begin
               cand_ok = 1'b0;
            end else if (cur_walk.sub == SUB_FIRST && f0 && along == '0) begin
               cand_ok       = 1'b1;
               cand_walk.sub = SUB_MID;
            end else if (cur_walk.sub == SUB_LAST && f2 && (along + EW'(2)) == ne) begin
               cand_ok = 1'b0;
            end else begin
               cand_ok = 1'b1;
            end
         end
         default: begin
            cand_ok = 1'b0;
         end
      endcase
   end

   // take the candidate or the first triangle of a later fan
   always_comb begin
      nxt_walk = cur_walk;
      nxt_x    = cur_x;
      nxt_y    = cur_y;
      if (phase_active(cur_walk.phase)) begin
         if (cand_ok) begin
            nxt_walk = cand_walk;
            nxt_x    = cand_x;
            nxt_y    = cand_y;
         end else begin
            nxt_x = '0;
            nxt_y = '0;
            if (after_up && edges.up && cells_nz) begin
               nxt_walk.phase = PH_UP;
               nxt_walk.sub   = edges.left ? SUB_MID : SUB_FIRST;
            end else if (after_down && edges.down && cells_nz) begin
               nxt_walk.phase = PH_DOWN;
               nxt_walk.sub   = edges.left ? SUB_MID : SUB_FIRST;
            end else if (after_left && edges.left && cells_nz) begin
               nxt_walk.phase = PH_LEFT;
               nxt_walk.sub   = edges.up ? SUB_MID : SUB_FIRST;
            end else if (after_right && edges.right && cells_nz) begin
               nxt_walk.phase = PH_RIGHT;
               nxt_walk.sub   = edges.up ? SUB_MID : SUB_FIRST;
            end else begin
               nxt_walk.phase = PH_DONE;
               nxt_walk.sub   = SUB_FIRST;
            end
         end
      end
   end

endmodule

### src/lodpig_tri.sv
// vertex indices of the triangle at the current walk position
// depends on lodpig_pkg
module lodpig_tri import lodpig_pkg::*; #(
   parameter int CW = MAX_CHUNK_LOG2_DEF + 1
) (
   input  walk_type              walk,
   input  logic [CW-1:0]         cell_x,
   input  logic [CW-1:0]         cell_y,
   input  logic [CW-1:0]         cells,
   input  logic [CHUNK_W-1:0]    shift,
   output logic [VERTEX_W-1:0]   vertex_a,
   output logic [VERTEX_W-1:0]   vertex_b,
   output logic [VERTEX_W-1:0]   vertex_c
);

   localparam int VW = VERTEX_W;

   logic [VW-1:0] x0, x1, x2, y0, y1, y2, nl, nm, one;
   logic [VW-1:0] ax, ay, bx, by, cx, cy;

   // row-major index; side is cells + 1 and cells is a power of two
   function automatic logic [VW-1:0] vtx_idx(input logic [VW-1:0] col,
                                             input logic [VW-1:0] row,
                                             input logic [CHUNK_W-1:0] sh);
      vtx_idx = (row << sh) + row + col;
   endfunction

   assign x0  = VW'(cell_x);
   assign x1  = x0 + VW'(1);
   assign x2  = x0 + VW'(2);
   assign y0  = VW'(cell_y);
   assign y1  = y0 + VW'(1);
   assign y2  = y0 + VW'(2);
   assign nl  = VW'(cells);
   assign nm  = nl - VW'(1);
   assign one = VW'(1);

   // corner coordinates per phase and sub-triangle
   always_comb begin
      ax = '0; ay = '0; bx = '0; by = '0; cx = '0; cy = '0;
      case (walk.phase)
         PH_INNER: begin
            ax = x0; ay = y0;
            if (walk.sub == SUB_FIRST) begin
               bx = x1; by = y1; cx = x1; cy = y0;
            end else begin
               bx = x0; by = y1; cx = x1; cy = y1;
            end
         end
         PH_UP: begin
            case (walk.sub)
               SUB_FIRST: begin
                  ax = x0; ay = '0; bx = x0; by = one; cx = x1; cy = one;
               end
               SUB_MID: begin
                  ax = x0; ay = '0; bx = x1; by = one; cx = x2; cy = '0;
               end
               default: begin
                  ax = x2; ay = one; bx = x2; by = '0; cx = x1; cy = one;
               end
            endcase
         end
         PH_DOWN: begin
            case (walk.sub)
               SUB_FIRST: begin
                  ax = x1; ay = nm; bx = x0; by = nm; cx = x0; cy = nl;
               end
               SUB_MID: begin
                  ax = x2; ay = nl; bx = x1; by = nm; cx = x0; cy = nl;
               end
               default: begin
                  ax = x1; ay = nm; bx = x2; by = nl; cx = x2; cy = nm;
               end
            endcase
         end
         PH_LEFT: begin
            case (walk.sub)
               SUB_FIRST: begin
                  ax = one; ay = y1; bx = one; by = y0; cx = '0; cy = y0;
               end
               SUB_MID: begin
                  ax = '0; ay = y2; bx = one; by = y1; cx = '0; cy = y0;
               end
               default: begin
                  ax = one; ay = y1; bx = '0; by = y2; cx = one; cy = y2;
               end
            endcase
         end
         default: begin
            // right fan
            case (walk.sub)
               SUB_FIRST: begin
                  ax = nl; ay = y0; bx = nm; by = y0; cx = nm; cy = y1;
               end
               SUB_MID: begin
                  ax = nl; ay = y0; bx = nm; by = y1; cx = nl; cy = y2;
               end
               default: begin
                  ax = nm; ay = y2; bx = nl; by = y2; cx = nm; cy = y1;
               end
            endcase
         end
      endcase
   end

   assign vertex_a = vtx_idx(ax, ay, shift);
   assign vertex_b = vtx_idx(bx, by, shift);
   assign vertex_c = vtx_idx(cx, cy, shift);

endmodule

### src/lod_patch_index_generator.sv
// Patch index generator: emits the triangle list of one square patch at a
// chosen level of detail, with crack-free stitching on flagged edges.
// Channels: req (tuser = op, 0 start / 1 advance; tdata = level and edge
// flags) and rsp (one transfer per advance: three vertex indices, running
// count and bad flag in tdata, triangle_valid on tuser, last_triangle on
// tlast). A start produces no rsp transfer.
// The csr port writes chunk_log2 (log2 of cells per side, reset value 5).
// The result of an advance sits in the output register in the cycle after
// its req transfer. Throughput: one item per cycle unless rsp stalls or a
// csr write is pending, set by the single walk-position register that the
// next-triangle search updates. In the cycle after a csr write, req_tready
// is low while the stored position is re-resolved against the new patch size.
// The output register holds one result; req_tready follows its free state,
// so a stalled receiver stops input with no item lost.
// Reset (synchronous) empties the output register, returns the walk to
// idle, clears count and bad flag, and sets chunk_log2 to 5.
// Depends on lodpig_pkg, lodpig_seek, lodpig_tri and the macros header.
`include "lod_patch_index_generator_macros.svh"

module lod_patch_index_generator import lodpig_pkg::*; #(
   parameter int MAX_CHUNK_LOG2 = MAX_CHUNK_LOG2_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration write
   input  logic                    csr_wr_en,
   input  logic [CHUNK_W-1:0]      csr_wr_data,    // chunk_log2
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,      // level[2:0], edge_left, edge_right,
                                                   // edge_up, edge_down, zero pad
   input  logic                    req_tuser,      // op
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,      // vertex_a, vertex_b, vertex_c,
                                                   // triangle_count, bad_request, zero pad
   output logic                    rsp_tuser,      // triangle_valid
   output logic                    rsp_tlast       // last_triangle
);

   localparam int CW = MAX_CHUNK_LOG2 + 1;
   localparam logic [CHUNK_W-1:0] MAX_LG = CHUNK_W'(MAX_CHUNK_LOG2);

   // state
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic                reseek_ff, reseek_in;
   walk_type            walk_ff, walk_in;
   logic [CW-1:0]       x_ff, x_in, y_ff, y_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   edges_type           edges_ff, edges_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                bad_ff, bad_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;
   logic                rsp_tri_ff, rsp_tri_in, rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_bad_ff, rsp_bad_in;

   // request decode and control
   logic                accept, take_start, take_adv, active, last_now, start_bad;
   logic [LEVEL_W-1:0]  req_level, lvl_sel;
   edges_type           req_edges, edges_sel;
   logic [CHUNK_W-1:0]  lg, shift;
   logic                too_fine;
   logic [CW-1:0]       cells;
   logic [COUNT_W-1:0]  count_inc;

   // walk datapath
   walk_type            adv_walk, src_walk, sk_walk;
   logic [CW-1:0]       adv_x, adv_y, src_x, src_y, sk_x, sk_y;
   logic [VERTEX_W-1:0] tri_a, tri_b, tri_c;

   assign req_level = req_tdata[2:0];
   assign req_edges = edges_type'({req_tdata[6], req_tdata[5], req_tdata[4], req_tdata[3]});

   // handshake: hold off in the cycle after a csr write, else follow the output slot
   assign req_tready = !reseek_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign take_start = accept && (req_tuser == OP_START);
   assign take_adv   = accept && (req_tuser == OP_ADVANCE);
   assign active     = phase_active(walk_ff.phase);

   // patch size from the saturated chunk size and the level in use
   assign lvl_sel   = take_start ? req_level : level_ff;
   assign edges_sel = take_start ? req_edges : edges_ff;
   assign lg        = (chunk_ff > MAX_LG) ? MAX_LG : chunk_ff;
   assign too_fine  = CHUNK_W'(lvl_sel) > lg;
   assign shift     = lg - CHUNK_W'(lvl_sel);
   assign cells     = too_fine ? '0 : (CW'(1) << shift);
   assign start_bad = (edges_sel != 4'b0000) && (cells < CW'(2));
   assign count_inc = count_ff + COUNT_W'(1);

   // step past the current triangle
   always_comb begin
      adv_walk = walk_ff;
      adv_x    = x_ff;
      adv_y    = y_ff;
      if (walk_ff.phase == PH_INNER) begin
         if (walk_ff.sub == SUB_FIRST) begin
            adv_walk.sub = SUB_MID;
         end else begin
            adv_walk.sub = SUB_FIRST;
            adv_x        = x_ff + CW'(1);
         end
      end else if (walk_ff.sub != SUB_LAST) begin
         adv_walk.sub = walk_ff.sub + SUB_W'(1);
      end else begin
         adv_walk.sub = SUB_FIRST;
         if (walk_ff.phase == PH_UP || walk_ff.phase == PH_DOWN) begin
            adv_x = x_ff + CW'(2);
         end else begin
            adv_y = y_ff + CW'(2);
         end
      end
   end

   // search start point
   always_comb begin
      src_walk = walk_ff;
      src_x    = x_ff;
      src_y    = y_ff;
      if (take_start) begin
         src_walk.phase = PH_INNER;
         src_walk.sub   = SUB_FIRST;
         src_x          = '0;
         src_y          = '0;
      end else if (take_adv) begin
         src_walk = adv_walk;
         src_x    = adv_x;
         src_y    = adv_y;
      end
   end

   lodpig_seek #(.CW(CW)) u_seek (
      .cur_walk (src_walk),
      .cur_x    (src_x),
      .cur_y    (src_y),
      .cells    (cells),
      .edges    (edges_sel),
      .nxt_walk (sk_walk),
      .nxt_x    (sk_x),
      .nxt_y    (sk_y)
   );

   lodpig_tri #(.CW(CW)) u_tri (
      .walk     (walk_ff),
      .cell_x   (x_ff),
      .cell_y   (y_ff),
      .cells    (cells),
      .shift    (shift),
      .vertex_a (tri_a),
      .vertex_b (tri_b),
      .vertex_c (tri_c)
   );

   assign last_now = (sk_walk.phase == PH_DONE);

   // next walk state
   always_comb begin
      chunk_in  = csr_wr_en ? csr_wr_data : chunk_ff;
      reseek_in = csr_wr_en;
      walk_in   = walk_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      level_in  = level_ff;
      edges_in  = edges_ff;
      count_in  = count_ff;
      bad_in    = bad_ff;
      if (take_start) begin
         level_in = req_level;
         edges_in = req_edges;
         count_in = '0;
         bad_in   = start_bad;
         if (start_bad) begin
            walk_in.phase = PH_DONE;
            walk_in.sub   = SUB_FIRST;
            x_in          = '0;
            y_in          = '0;
         end else begin
            walk_in = sk_walk;
            x_in    = sk_x;
            y_in    = sk_y;
         end
      end else if (take_adv && active) begin
         walk_in  = sk_walk;
         x_in     = sk_x;
         y_in     = sk_y;
         count_in = count_inc;
      end else if (reseek_ff) begin
         walk_in = sk_walk;
         x_in    = sk_x;
         y_in    = sk_y;
      end
   end

   // result register load on an advance transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      rsp_tri_in   = rsp_tri_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (take_adv) begin
         rsp_valid_in = 1'b1;
         rsp_bad_in   = bad_ff;
         if (active) begin
            rsp_a_in     = tri_a;
            rsp_b_in     = tri_b;
            rsp_c_in     = tri_c;
            rsp_tri_in   = 1'b1;
            rsp_last_in  = last_now;
            rsp_count_in = count_inc;
         end else begin
            rsp_a_in     = '0;
            rsp_b_in     = '0;
            rsp_c_in     = '0;
            rsp_tri_in   = 1'b0;
            rsp_last_in  = 1'b0;
            rsp_count_in = count_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= CHUNK_RESET;
         reseek_ff    <= 1'b0;
         walk_ff      <= '{phase: PH_IDLE, sub: SUB_FIRST};
         x_ff         <= '0;
         y_ff         <= '0;
         level_ff     <= '0;
         edges_ff     <= '0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         reseek_ff    <= reseek_in;
         walk_ff      <= walk_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         level_ff     <= level_in;
         edges_ff     <= edges_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_tri_ff   <= rsp_tri_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_bad_ff, rsp_count_ff,
                        rsp_c_ff, rsp_b_ff, rsp_a_ff};
   assign rsp_tuser  = rsp_tri_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `LODPIG_ASSERT_NEXT(a_last_ends_list, clock, reset, take_adv && active && last_now, walk_ff.phase == PH_DONE)
   `LODPIG_ASSERT_NEXT(a_count_step, clock, reset, take_adv && active, count_ff == COUNT_W'($past(count_ff) + 1'b1))
   `LODPIG_ASSERT_NEXT(a_cfg_stall, clock, reset, csr_wr_en, !req_tready)
   `LODPIG_ASSERT_NOW(a_bad_is_done, clock, reset, bad_ff, walk_ff.phase == PH_DONE)

endmodule
